// ===== rtl/core/bpk_pkg.sv =====
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and constants for the bit packer feeding a paged byte memory.
// ----------------------------------------------------------------------------
package bpk_pkg;

    localparam int PAGE_BYTES  = 64;
    localparam int PAGE_COUNT  = 512;
    localparam int MEM_BYTES   = PAGE_BYTES * PAGE_COUNT;
    localparam int CNT_MAX     = 1023;
    localparam int CNT_LIMIT   = (PAGE_COUNT > CNT_MAX) ? CNT_MAX : PAGE_COUNT;
    localparam int OFF_W       = $clog2(PAGE_BYTES);

    localparam int ADDR_W      = 15;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 10;
    localparam int WORD_W      = 16;
    localparam int BCNT_W      = 5;
    localparam int MODE_W      = 2;
    localparam int PEND_W      = 3;
    localparam int PART_W      = 7;
    localparam int ACC_W       = 24;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic [CNT_W-1:0]  NF_RESET  = 10'd452;
    localparam logic [BCNT_W-1:0] MAX_BITS  = 5'd16;
    localparam logic [BCNT_W-1:0] BYTE_BITS = 5'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 2'd0,
        MODE_FLUSH     = 2'd1,
        MODE_CLR_PAGES = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [OFF_W-1:0]  off;
        logic [CNT_W-1:0]  pc;
    } t_pos;

    typedef struct packed {
        logic              last;
        logic              near_full;
        logic [CNT_W-1:0]  pages;
        logic [BYTE_W-1:0] value;
        logic [ADDR_W-1:0] addr;
    } t_result;

    function automatic t_pos step_pos(t_pos cur);
        t_pos nxt;
        logic page_end;
        page_end = (32'(cur.off) == PAGE_BYTES - 1);
        nxt      = cur;
        if (page_end) begin
            nxt.off = '0;
            if (32'(cur.pc) < CNT_LIMIT) begin
                nxt.pc = cur.pc + CNT_W'(1);
            end
            if (32'(cur.addr) + 32'd1 >= MEM_BYTES) begin
                nxt.addr = '0;
            end else begin
                nxt.addr = cur.addr + ADDR_W'(1);
            end
        end else begin
            nxt.off  = cur.off + OFF_W'(1);
            nxt.addr = cur.addr + ADDR_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/bit_packer_to_paged_memory.sv =====
// ----------------------------------------------------------------------------
// bit_packer_to_paged_memory
// MSB-first bit packer; emits each completed byte with its paged address.
// ----------------------------------------------------------------------------
// The first byte of an item is registered and appears in the cycle after the input beat.
// Throughput: one item per cycle while items complete at most one byte and
// the receiver is ready; an item completing two bytes fills the two-entry
// output buffer and stalls the input, as one output beat leaves per cycle.
// Reset: synchronous, active low; clears bit, address and page state and
// loads the near-full threshold with 452.
module bit_packer_to_paged_memory (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpk_pkg::CNT_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [15:0] data_word, [20:16] bit_count, rest zero
    input  logic [bpk_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [1:0] mode
    input  logic [bpk_pkg::MODE_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [14:0] byte_addr, [22:15] byte_value, [32:23] pages_used,
    // [33] near_full, rest zero
    output logic [bpk_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast
);
    import bpk_pkg::*;

    logic [CNT_W-1:0]  r_nfp;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [PART_W-1:0] r_part, n_part;
    t_pos              r_pos, n_pos;
    t_result           r_slot [2];
    logic [1:0]        r_cnt;

    logic              s_acc, m_fire;
    logic              is_app, is_flush, is_clr, act;
    logic [BCNT_W-1:0] nbits, tot;
    logic [WORD_W-1:0] word_eff;
    logic [16:0]       mask17;
    logic [ACC_W-1:0]  acc, aligned;
    logic [BYTE_W-1:0] rem_mask;
    logic [1:0]        nbytes;
    t_pos              pos1, pos2;
    t_result           res0, res1;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign m_fire = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = M_TDATA_W'({r_slot[0].near_full, r_slot[0].pages,
                                    r_slot[0].value, r_slot[0].addr});
    assign o_m_tlast  = r_slot[0].last;

    always_comb begin
        is_app   = 1'b0;
        is_flush = 1'b0;
        is_clr   = 1'b0;
        unique case (i_s_tuser)
            MODE_APPEND:    is_app   = 1'b1;
            MODE_FLUSH:     is_flush = 1'b1;
            MODE_CLR_PAGES: is_clr   = 1'b1;
            default:        ;
        endcase
        act = is_app || is_flush;

        if (is_app) begin
            nbits    = (i_s_tdata[20:16] > MAX_BITS) ? MAX_BITS : i_s_tdata[20:16];
            word_eff = i_s_tdata[WORD_W-1:0];
        end else begin
            nbits    = BYTE_BITS - BCNT_W'(r_pend);
            word_eff = '0;
        end

        mask17   = (17'd1 << nbits) - 17'd1;
        acc      = (ACC_W'(r_part) << nbits) | ACC_W'(word_eff & mask17[WORD_W-1:0]);
        tot      = BCNT_W'(r_pend) + nbits;
        aligned  = acc << (5'd24 - tot);
        rem_mask = (8'd1 << tot[2:0]) - 8'd1;
        nbytes   = act ? tot[4:3] : 2'd0;

        pos1 = step_pos(r_pos);
        pos2 = step_pos(pos1);

        res0.addr      = r_pos.addr;
        res0.value     = aligned[23:16];
        res0.pages     = pos1.pc;
        res0.near_full = (pos1.pc >= r_nfp);
        res0.last      = (nbytes == 2'd1);
        res1.addr      = pos1.addr;
        res1.value     = aligned[15:8];
        res1.pages     = pos2.pc;
        res1.near_full = (pos2.pc >= r_nfp);
        res1.last      = 1'b1;

        n_pend = r_pend;
        n_part = r_part;
        n_pos  = r_pos;
        if (act) begin
            n_pend = tot[2:0];
            n_part = acc[PART_W-1:0] & rem_mask[PART_W-1:0];
            unique case (nbytes)
                2'd0:    n_pos = r_pos;
                2'd1:    n_pos = pos1;
                default: n_pos = pos2;
            endcase
        end else if (is_clr) begin
            n_pos.pc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfp  <= NF_RESET;
            r_pend <= '0;
            r_part <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nfp <= i_cfg_wdata;
            end
            if (s_acc) begin
                r_pend <= n_pend;
                r_part <= n_part;
                r_pos  <= n_pos;
                r_cnt  <= nbytes;
            end else if (m_fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_slot[0] <= res0;
            r_slot[1] <= res1;
        end else if (m_fire) begin
            r_slot[0] <= r_slot[1];
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_s_tready && !o_m_tlast)
        else $error("full buffer must stall input and hold a non-last beat");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> o_m_tlast)
        else $error("lone buffered beat must be last");

    a_clr_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && is_clr |=> r_pos.pc == '0)
        else $error("page counter not cleared");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !act |=> r_cnt == 2'd0)
        else $error("result produced by a non-packing item");

endmodule

// ===== tb/sv/tb_bit_packer_to_paged_memory.sv =====
// ----------------------------------------------------------------------------
// tb_bit_packer_to_paged_memory
// Self-checking bench for the MSB-first bit packer with paged byte addressing.
// A table of directed items opens the run, then random items under several
// near-full thresholds. Every output beat is compared field by field with a
// bench-side packer that tracks bits, address and pages.
// ----------------------------------------------------------------------------
module tb_bit_packer_to_paged_memory;

    timeunit 1ns;
    timeprecision 1ps;

    import bpk_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int MAX_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] word;
        logic [BCNT_W-1:0] nbits;
        logic              typed;
        logic [1:0]        nres;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
    } t_row;

    // mode, word, bit count, typed, bytes, first byte, second byte
    localparam t_row DIRECTED [23] = '{
        '{MODE_APPEND,    16'hFFFF, 5'd16, 1'b1, 2'd2, 8'hFF, 8'hFF},
        '{MODE_APPEND,    16'h0000, 5'd16, 1'b1, 2'd2, 8'h00, 8'h00},
        '{MODE_APPEND,    16'h00A5, 5'd8,  1'b1, 2'd1, 8'hA5, 8'h00},
        '{MODE_APPEND,    16'hFFFF, 5'd0,  1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'h1234, 5'd31, 1'b1, 2'd2, 8'h12, 8'h34},
        '{MODE_APPEND,    16'hABCD, 5'd17, 1'b1, 2'd2, 8'hAB, 8'hCD},
        '{MODE_FLUSH,     16'h0000, 5'd0,  1'b1, 2'd1, 8'h00, 8'h00},
        '{MODE_APPEND,    16'hFFFD, 5'd3,  1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_FLUSH,     16'hFFFF, 5'd31, 1'b1, 2'd1, 8'hA0, 8'h00},
        '{MODE_APPEND,    16'h0001, 5'd1,  1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'h8001, 5'd16, 1'b1, 2'd2, 8'hC0, 8'h00},
        '{MODE_FLUSH,     16'h0000, 5'd0,  1'b1, 2'd1, 8'h80, 8'h00},
        '{MODE_CLR_PAGES, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_IGNORED,   16'hFFFF, 5'd16, 1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'h007F, 5'd7,  1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'h01FF, 5'd9,  1'b1, 2'd2, 8'hFF, 8'hFF},
        '{MODE_APPEND,    16'hFF00, 5'd8,  1'b1, 2'd1, 8'h00, 8'h00},
        '{MODE_CLR_PAGES, 16'hFFFF, 5'd31, 1'b1, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'hFFFF, 5'd15, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{MODE_FLUSH,     16'h0000, 5'd8,  1'b1, 2'd1, 8'hFE, 8'h00},
        '{MODE_APPEND,    16'h5A3C, 5'd13, 1'b0, 2'd0, 8'h00, 8'h00},
        '{MODE_APPEND,    16'hC3E1, 5'd11, 1'b0, 2'd0, 8'h00, 8'h00},
        '{MODE_FLUSH,     16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CNT_W-1:0]     i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;   // [15:0] data_word, [20:16] bit_count
    logic [MODE_W-1:0]    i_s_tuser;   // [1:0] mode
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;   // [14:0] addr, [22:15] byte, [32:23] pages, [33] near_full
    logic                 o_m_tlast;

    // bench-side packer state
    logic [BYTE_W-1:0] acc_bits;
    int                acc_count;
    logic [ADDR_W-1:0] next_addr;
    logic [CNT_W-1:0]  page_tally;
    logic [CNT_W-1:0]  nf_thresh;

    t_result bytes_due[$];
    t_result new_bytes[$];

    int  errors;
    int  cycle_count;
    int  stall_left;
    int  hold_left;
    bit  tx_idle;
    bit  rx_idle;

    bit_packer_to_paged_memory dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void emit_packed_byte(input logic [BYTE_W-1:0] v);
        t_result r;
        int      nxt;
        r       = '0;
        r.addr  = next_addr;
        r.value = v;
        nxt     = int'(next_addr) + 1;
        if (nxt % PAGE_BYTES == 0) begin
            if (int'(page_tally) < CNT_LIMIT) begin
                page_tally = page_tally + 1'b1;
            end
            if (nxt >= MEM_BYTES) begin
                nxt = 0;
            end
        end
        next_addr   = ADDR_W'(nxt);
        r.pages     = page_tally;
        r.near_full = (page_tally >= nf_thresh);
        new_bytes.push_back(r);
    endfunction

    function automatic void shift_in_bits(input logic [WORD_W-1:0] word, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            acc_bits  = {acc_bits[BYTE_W-2:0], word[i]};
            acc_count = acc_count + 1;
            if (acc_count == int'(BYTE_BITS)) begin
                emit_packed_byte(acc_bits);
                acc_count = 0;
                acc_bits  = '0;
            end
        end
    endfunction

    function automatic void pack_item(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] w,
                                      input logic [BCNT_W-1:0] c);
        new_bytes.delete();
        case (m)
            MODE_APPEND: begin
                shift_in_bits(w, (c > MAX_BITS) ? int'(MAX_BITS) : int'(c));
            end
            MODE_FLUSH: begin
                shift_in_bits('0, int'(BYTE_BITS) - acc_count);
            end
            MODE_CLR_PAGES: begin
                page_tally = '0;
            end
            default: begin
            end
        endcase
        if (new_bytes.size() > 0) begin
            new_bytes[new_bytes.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // enter at a falling edge; return at the rising edge that takes the beat
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] w,
                             input logic [BCNT_W-1:0] c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, c, w};
        i_s_tuser  <= m;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pack_item(m, w, c);
    endtask

    task automatic post_item();
        foreach (new_bytes[k]) bytes_due.push_back(new_bytes[k]);
        @(negedge i_clk);
    endtask

    task automatic feed(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] w,
                        input logic [BCNT_W-1:0] c);
        send_item(m, w, c);
        post_item();
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (bytes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [CNT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        nf_thresh    = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_run(input int n, input int clear_pct);
        logic [MODE_W-1:0] m;
        logic [BCNT_W-1:0] c;
        int                r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < clear_pct) begin
                m = MODE_CLR_PAGES;
            end else if (r < 75) begin
                m = MODE_APPEND;
            end else if (r < 93) begin
                m = MODE_FLUSH;
            end else begin
                m = MODE_IGNORED;
            end
            if ($urandom_range(0, 9) == 0) begin
                c = BCNT_W'($urandom_range(17, 31));
            end else begin
                c = BCNT_W'($urandom_range(0, 16));
            end
            feed(m, WORD_W'($urandom), c);
        end
    endtask

    // receiver: hold off on request, else stall per beat as drawn
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got        = {o_m_tlast, o_m_tdata[33:0]};
            stall_left = rx_idle ? $urandom_range(0, 17) : 0;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none got addr %0d byte %02h",
                         $time, got.addr, got.value);
            end else begin
                want = bytes_due.pop_front();
                check_field("byte_addr", want.addr, got.addr);
                check_field("byte_value", want.value, got.value);
                check_field("pages_used", want.pages, got.pages);
                check_field("near_full", want.near_full, got.near_full);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        t_row row;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        errors      = 0;
        cycle_count = 0;
        stall_left  = 0;
        hold_left   = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        acc_bits    = '0;
        acc_count   = 0;
        next_addr   = '0;
        page_tally  = '0;
        nf_thresh   = NF_RESET;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            send_item(row.mode, row.word, row.nbits);
            if (row.typed) begin
                check_field("bytes per item", row.nres, new_bytes.size());
                foreach (new_bytes[k]) new_bytes[k].value = (k == 0) ? row.b0 : row.b1;
            end
            post_item();
        end
        wait_drained();

        set_threshold(10'd0);
        random_run(370, 4);
        wait_drained();

        // hold the output off while items keep coming
        set_threshold(10'd512);
        tx_idle = 1'b0;
        @(posedge i_clk);
        hold_left = 400;
        @(negedge i_clk);
        random_run(370, 4);
        wait_drained();

        set_threshold(10'd1);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        random_run(370, 2);
        wait_drained();

        set_threshold(10'd3);
        tx_idle = 1'b0;
        random_run(370, 1);
        wait_drained();

        set_threshold(10'd511);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_run(370, 2);
        wait_drained();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
